// File: rtl/btlv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btlv_pkg
// Shared types and constants of the BER tag-length-value element decoder:
// parser phases, result kinds, the per-element state record and the bundle
// of results that one input byte produces.
// ----------------------------------------------------------------------------
package btlv_pkg;

  typedef enum logic [1:0] {
    PH_TAG     = 2'd0,
    PH_LEN     = 2'd1,
    PH_LONGLEN = 2'd2,
    PH_CONTENT = 2'd3
  } phase_t;

  // Result kinds.
  localparam logic [1:0] K_BYTE = 2'd0;
  localparam logic [1:0] K_OID  = 2'd1;
  localparam logic [1:0] K_DONE = 2'd2;
  localparam logic [1:0] K_ERR  = 2'd3;

  // Error causes.
  localparam logic CAUSE_BAD_COUNT = 1'b0;
  localparam logic CAUSE_EARLY_END = 1'b1;

  localparam logic [7:0] OID_TAG      = 8'h06;
  localparam logic [2:0] MAX_LEN_BYTES = 3'd4;

  // Division of a byte by 40: q = (b * 205) >> 13 is exact for b < 256.
  localparam logic [7:0]  OID_FIRST_DIV = 8'd40;
  localparam logic [15:0] DIV40_MUL     = 16'd205;
  localparam int          DIV40_SHIFT   = 13;

  // Slots in one bundle: content byte, two OID parts, done or error.
  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  tag;
    logic [31:0] dlen;
    logic [31:0] remaining;
    logic [2:0]  len_left;
    logic [63:0] acc;
    logic [31:0] oid_acc;
    logic        first;
  } elem_state_t;

  localparam elem_state_t ELEM_CLEAR = '{
    phase:     PH_TAG,
    tag:       8'd0,
    dlen:      32'd0,
    remaining: 32'd0,
    len_left:  3'd0,
    acc:       64'd0,
    oid_acc:   32'd0,
    first:     1'b1
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] part;
    logic [3:0]  idx;
    logic        cause;
  } slot_t;

  typedef struct packed {
    logic [2:0]                   n;
    logic [7:0]                   tag;
    logic [31:0]                  clen;
    logic [63:0]                  ival;
    logic [7:0]                   pbyte;
    slot_t [MAX_RESULTS-1:0]      slot;
  } bundle_t;

endpackage
`default_nettype wire

// File: rtl/ber_tlv_element_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ber_tlv_element_decoder_top
// Byte-serial decoder for flat BER tag-length-value elements with content
// echo, integer gathering and OBJECT IDENTIFIER component decoding.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake           | Payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid, in_stall  | data_byte, end_of_buffer
//   output  | out_valid, out_stall| kind, element_tag, payload_byte, oid_part,
//           |                     | oid_part_index, content_length, int_value,
//           |                     | error_cause, last_of_run
//
// A byte is parsed in the cycle it is accepted and gives zero to four
// results; any that it gives are written as one bundle into a two-entry
// bundle buffer and leave on the output one per cycle while out_stall is
// low. The sustained rate is one byte per cycle while bytes give at most one
// result each and out_stall stays low; otherwise the output port sets it.
// in_stall is high only while both bundle entries are occupied.
// Reset is synchronous and clears the parser state and the bundle buffer.
// ----------------------------------------------------------------------------
module ber_tlv_element_decoder_top #(
  parameter int MAX_OID_PARTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               end_of_buffer,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [7:0]         element_tag,
  output logic [7:0]         payload_byte,
  output logic [31:0]        oid_part,
  output logic [3:0]         oid_part_index,
  output logic [31:0]        content_length,
  output logic signed [63:0] int_value,
  output logic               error_cause,
  output logic               last_of_run
);
  import btlv_pkg::*;

  // The OID part counter must be able to hold MAX_OID_PARTS itself.
  localparam int CW = $clog2(MAX_OID_PARTS + 1);

  elem_state_t   st, st_next;
  logic [CW-1:0] parts, parts_next;
  bundle_t       bund;

  bundle_t       bund_q [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    fifo_cnt;
  logic [1:0]    slot_ptr;

  logic          in_accept, push, pop, out_take;
  bundle_t       head;
  slot_t         cur;

  btlv_step #(
    .MAX_OID_PARTS(MAX_OID_PARTS),
    .CW           (CW)
  ) u_step (
    .st           (st),
    .parts        (parts),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .st_next      (st_next),
    .parts_next   (parts_next),
    .bund         (bund)
  );

  // The input side only waits when both bundle entries are still draining.
  assign in_stall  = (fifo_cnt == 2'd2);
  assign in_accept = in_valid && !in_stall;
  // Bytes that produce no result (most tag and length bytes) leave no bundle.
  assign push      = in_accept && (bund.n != 3'd0);

  assign head      = bund_q[rd_ptr];
  assign cur       = head.slot[slot_ptr];
  assign out_valid = (fifo_cnt != 2'd0);
  assign out_take  = out_valid && !out_stall;
  assign pop       = out_take && last_of_run;

  // Parser state advances with every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ELEM_CLEAR;
      parts <= '0;
    end else if (in_accept) begin
      st    <= st_next;
      parts <= parts_next;
    end
  end

  // Bundle buffer: two entries written in turn and drained in order.
  always_ff @(posedge clk) begin
    if (push) begin
      bund_q[wr_ptr] <= bund;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fifo_cnt <= 2'd0;
      slot_ptr <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fifo_cnt <= fifo_cnt + 2'(push) - 2'(pop);
      if (out_take) begin
        slot_ptr <= last_of_run ? 2'd0 : slot_ptr + 2'd1;
      end
    end
  end

  // The result fields shared by a whole bundle come from the bundle header;
  // kind-specific fields come from the current slot.
  assign kind           = cur.kind;
  assign element_tag    = head.tag;
  assign payload_byte   = (cur.kind == K_BYTE) ? head.pbyte : 8'd0;
  assign oid_part       = cur.part;
  assign oid_part_index = cur.idx;
  assign content_length = head.clen;
  assign int_value      = head.ival;
  assign error_cause    = cur.cause;
  assign last_of_run    = ({1'b0, slot_ptr} == head.n - 3'd1);

`ifndef NO_ASSERTIONS
  // A bundle is never left half delivered.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("output run ended before its last result");

  // The slot pointer only moves away from zero inside a pending bundle.
  a_slot_in_bundle: assert property (@(posedge clk) disable iff (rst)
    slot_ptr != 2'd0 |-> out_valid)
    else $error("slot pointer set with no bundle pending");

  // Element completion and errors always close the run of their byte.
  a_terminal_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == K_DONE || kind == K_ERR) |-> last_of_run)
    else $error("done or error result not last of its run");

  // The bundle buffer holds at most two entries.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt != 2'd3)
    else $error("bundle buffer overflow");
`endif

endmodule
`default_nettype wire

// File: rtl/btlv_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btlv_step
// One parser step: from the element state and one byte, the next state and
// the bundle of up to four results that the byte produces.
// ----------------------------------------------------------------------------
module btlv_step #(
  parameter int MAX_OID_PARTS = 16,
  parameter int CW            = 5
) (
  input  btlv_pkg::elem_state_t st,
  input  logic [CW-1:0]         parts,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_buffer,
  output btlv_pkg::elem_state_t st_next,
  output logic [CW-1:0]         parts_next,
  output btlv_pkg::bundle_t     bund
);
  import btlv_pkg::*;

  logic        in_len, in_longlen, in_content;
  logic        short_form, bad_count;
  logic [6:0]  count_field;
  logic [31:0] dlen_shift;
  logic [2:0]  len_left_dec;
  logic        long_done;
  logic [31:0] rem_dec;
  logic        content_done;
  logic [63:0] acc_new;
  logic        is_oid;
  logic [31:0] oid_acc_shift;
  logic [15:0] div_prod;
  logic [7:0]  oid_q, oid_r;
  logic        oid_first, oid_next;
  logic        done, end_err;

  assign in_len     = (st.phase == PH_LEN);
  assign in_longlen = (st.phase == PH_LONGLEN);
  assign in_content = (st.phase == PH_CONTENT);

  assign short_form  = ~data_byte[7];
  assign count_field = data_byte[6:0];
  assign bad_count   = in_len && data_byte[7] &&
                       (count_field == 7'd0 || count_field > 7'(MAX_LEN_BYTES));

  assign dlen_shift   = {st.dlen[23:0], data_byte};
  assign len_left_dec = st.len_left - 3'(st.len_left != 3'd0);
  assign long_done    = (len_left_dec == 3'd0);

  assign rem_dec      = st.remaining - 32'(st.remaining != 32'd0);
  assign content_done = (rem_dec == 32'd0);

  assign acc_new = st.first ? {{56{data_byte[7]}}, data_byte}
                            : {st.acc[55:0], data_byte};

  assign is_oid        = (st.tag == OID_TAG);
  assign oid_acc_shift = {st.oid_acc[24:0], data_byte[6:0]};
  assign div_prod      = {8'd0, data_byte} * DIV40_MUL;
  assign oid_q         = 8'(div_prod >> DIV40_SHIFT);
  assign oid_r         = data_byte - 8'(oid_q * OID_FIRST_DIV);

  assign oid_first = in_content && is_oid && st.first;
  assign oid_next  = in_content && is_oid && !st.first &&
                     (parts < CW'(MAX_OID_PARTS)) && !data_byte[7];

  assign done = (in_len && short_form && data_byte == 8'd0) ||
                (in_longlen && long_done && dlen_shift == 32'd0) ||
                (in_content && content_done);
  assign end_err = !done && end_of_buffer && !bad_count;

  // Next element state.
  always_comb begin
    st_next    = st;
    parts_next = parts;
    unique case (st.phase)
      PH_TAG: begin
        st_next       = ELEM_CLEAR;
        st_next.tag   = data_byte;
        st_next.phase = PH_LEN;
        parts_next    = '0;
      end
      PH_LEN: begin
        if (short_form) begin
          st_next.dlen      = {24'd0, data_byte};
          st_next.remaining = {24'd0, data_byte};
          st_next.phase     = PH_CONTENT;
        end else if (bad_count) begin
          st_next.phase = PH_TAG;
        end else begin
          st_next.dlen     = 32'd0;
          st_next.len_left = count_field[2:0];
          st_next.phase    = PH_LONGLEN;
        end
      end
      PH_LONGLEN: begin
        st_next.dlen     = dlen_shift;
        st_next.len_left = len_left_dec;
        if (long_done) begin
          st_next.remaining = dlen_shift;
          st_next.phase     = PH_CONTENT;
        end
      end
      PH_CONTENT: begin
        st_next.acc = acc_new;
        if (is_oid) begin
          if (st.first) begin
            parts_next = CW'(2);
          end else if (parts < CW'(MAX_OID_PARTS)) begin
            st_next.oid_acc = data_byte[7] ? oid_acc_shift : 32'd0;
            if (!data_byte[7]) begin
              parts_next = parts + CW'(1);
            end
          end
        end
        st_next.first     = 1'b0;
        st_next.remaining = rem_dec;
      end
    endcase
    if (done || end_err) begin
      st_next.phase = PH_TAG;
    end
  end

  // Results of this byte, in order.
  always_comb begin
    logic [2:0] k;
    k          = 3'd0;
    bund       = '0;
    bund.tag   = st_next.tag;
    bund.clen  = st_next.dlen;
    bund.ival  = st_next.acc;
    bund.pbyte = data_byte;
    if (in_content) begin
      bund.slot[k[1:0]].kind = K_BYTE;
      k = k + 3'd1;
    end
    if (oid_first) begin
      bund.slot[k[1:0]].kind = K_OID;
      bund.slot[k[1:0]].part = {24'd0, oid_q};
      bund.slot[k[1:0]].idx  = 4'd0;
      k = k + 3'd1;
      bund.slot[k[1:0]].kind = K_OID;
      bund.slot[k[1:0]].part = {24'd0, oid_r};
      bund.slot[k[1:0]].idx  = 4'd1;
      k = k + 3'd1;
    end else if (oid_next) begin
      bund.slot[k[1:0]].kind = K_OID;
      bund.slot[k[1:0]].part = oid_acc_shift;
      bund.slot[k[1:0]].idx  = 4'(parts);
      k = k + 3'd1;
    end
    if (bad_count) begin
      bund.slot[k[1:0]].kind  = K_ERR;
      bund.slot[k[1:0]].cause = CAUSE_BAD_COUNT;
      k = k + 3'd1;
    end else if (done) begin
      bund.slot[k[1:0]].kind = K_DONE;
      k = k + 3'd1;
    end else if (end_err) begin
      bund.slot[k[1:0]].kind  = K_ERR;
      bund.slot[k[1:0]].cause = CAUSE_EARLY_END;
      k = k + 3'd1;
    end
    bund.n = k;
  end

endmodule
`default_nettype wire

// File: sim/ber_tlv_element_decoder_top_test.sv
// ----------------------------------------------------------------------------
// ber_tlv_element_decoder_top_test
// Self-checking bench for the byte-serial BER element decoder. Each byte that
// the decoder accepts is run through a bit-exact predictor. The predictor
// queues the results that the byte should cause, and a monitor compares every
// result that leaves the block against the oldest queued one. Stimulus is a
// short directed list followed by random elements, broken elements and noise.
// ----------------------------------------------------------------------------
module ber_tlv_element_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import btlv_pkg::*;

  // The decoder is built with its default component limit, and the predictor
  // uses the same number.
  localparam int OID_PART_LIMIT = 16;

  // A run fails if this many cycles pass with no item accepted on either side.
  // The longest legal quiet stretch is one long sender gap or receiver stall.
  localparam int QUIET_LIMIT = 2000;

  // Cycles to wait after the last expected result before the verdict. The
  // bundle buffer holds at most two bytes of up to four results each.
  localparam int SETTLE_CYCLES = 16;

  // Bit 7 of a length byte selects the long form. In OID content the same bit
  // marks a byte that continues a component.
  localparam logic [7:0] HIGH_BIT = 8'h80;

  // One input item as the driver presents it.
  typedef struct packed {
    logic [7:0] octet;
    logic       eob;
  } tlv_byte_t;

  // One result item with every field that the decoder reports.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic [7:0]  pbyte;
    logic [31:0] part;
    logic [3:0]  idx;
    logic [31:0] clen;
    logic [63:0] ival;
    logic        cause;
    logic        last;
  } tlv_result_t;

  // Clock, reset and the two channels. All inputs start at known values.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte     = 8'd0;
  logic               end_of_buffer = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [1:0]         kind;
  logic [7:0]         element_tag;
  logic [7:0]         payload_byte;
  logic [31:0]        oid_part;
  logic [3:0]         oid_part_index;
  logic [31:0]        content_length;
  logic signed [63:0] int_value;
  logic               error_cause;
  logic               last_of_run;

  ber_tlv_element_decoder_top #(
    .MAX_OID_PARTS(OID_PART_LIMIT)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_buffer  (end_of_buffer),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .element_tag    (element_tag),
    .payload_byte   (payload_byte),
    .oid_part       (oid_part),
    .oid_part_index (oid_part_index),
    .content_length (content_length),
    .int_value      (int_value),
    .error_cause    (error_cause),
    .last_of_run    (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be driven, and results that the decoder still owes.
  tlv_byte_t   byte_q[$];
  tlv_result_t owed_q[$];

  // Bookkeeping for the summary and the verdict.
  int items_queued    = 0;
  int bytes_fed       = 0;
  int results_checked = 0;
  int kind_seen[4]    = '{0, 0, 0, 0};
  int fail_count      = 0;

  // When set, neither side idles: the sender drives back to back and the
  // receiver never stalls.
  bit calm = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors what the decoder keeps about the element in
  // progress: parse phase, tag, declared and remaining length, the number of
  // long-form length bytes still due, the integer gathered so far, the OID
  // component being built and how many components went out.
  // --------------------------------------------------------------------------
  phase_t      parse_phase = PH_TAG;
  logic [7:0]  cur_tag     = 8'd0;
  logic [31:0] decl_len    = 32'd0;
  logic [31:0] left_bytes  = 32'd0;
  logic [2:0]  len_due     = 3'd0;
  logic [63:0] int_acc     = 64'd0;
  logic [31:0] oid_acc     = 32'd0;
  int          oid_emitted = 0;
  bit          first_body  = 1'b1;

  // A new tag starts from a clean element; the phase and tag are set apart.
  function automatic void clear_element();
    decl_len    = 32'd0;
    left_bytes  = 32'd0;
    len_due     = 3'd0;
    int_acc     = 64'd0;
    oid_acc     = 32'd0;
    oid_emitted = 0;
    first_body  = 1'b1;
  endfunction

  // Every result carries the element's tag, declared length and gathered
  // integer as they stand at the moment the result is formed.
  function automatic tlv_result_t make_result(logic [1:0] k, logic [7:0] pb,
                                              logic [31:0] pt, logic [3:0] ix,
                                              logic cs);
    tlv_result_t r;
    r.kind  = k;
    r.tag   = cur_tag;
    r.pbyte = pb;
    r.part  = pt;
    r.idx   = ix;
    r.clen  = decl_len;
    r.ival  = int_acc;
    r.cause = cs;
    r.last  = 1'b0;
    return r;
  endfunction

  // Advances the predictor by one accepted byte and queues its results in
  // order. The last of them carries last_of_run.
  task automatic predict_byte(input logic [7:0] b, input logic eob);
    tlv_result_t res[4];
    int          k;
    bit          done;
    bit          bad_count;
    k         = 0;
    done      = 1'b0;
    bad_count = 1'b0;
    case (parse_phase)
      PH_TAG: begin
        cur_tag = b;
        clear_element();
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        if (!b[7]) begin
          decl_len   = {24'd0, b};
          left_bytes = decl_len;
          if (b == 8'd0) done = 1'b1;
          else parse_phase = PH_CONTENT;
        end else if (b[6:0] == 7'd0 || b[6:0] > MAX_LEN_BYTES) begin
          // A bad byte count ends the element at once; end_of_buffer on this
          // byte adds nothing further.
          res[0]      = make_result(K_ERR, 8'd0, 32'd0, 4'd0, CAUSE_BAD_COUNT);
          k           = 1;
          bad_count   = 1'b1;
          parse_phase = PH_TAG;
        end else begin
          decl_len    = 32'd0;
          len_due     = b[2:0];
          parse_phase = PH_LONGLEN;
        end
      end
      PH_LONGLEN: begin
        // Long-form length bytes arrive most significant first, and the
        // partial value is visible while they come in.
        decl_len = {decl_len[23:0], b};
        if (len_due > 3'd0) len_due--;
        if (len_due == 3'd0) begin
          left_bytes = decl_len;
          if (decl_len == 32'd0) done = 1'b1;
          else parse_phase = PH_CONTENT;
        end
      end
      default: begin
        // The first content byte sets the sign of the gathered integer;
        // older bytes fall off the top after eight.
        if (first_body) int_acc = {64{b[7]}};
        int_acc = {int_acc[55:0], b};
        res[k] = make_result(K_BYTE, b, 32'd0, 4'd0, 1'b0);
        k++;
        if (cur_tag == OID_TAG) begin
          if (first_body) begin
            res[k] = make_result(K_OID, 8'd0, 32'(b / OID_FIRST_DIV), 4'd0, 1'b0);
            k++;
            res[k] = make_result(K_OID, 8'd0, 32'(b % OID_FIRST_DIV), 4'd1, 1'b0);
            k++;
            oid_emitted = 2;
          end else if (oid_emitted < OID_PART_LIMIT) begin
            // Base-128 digits pile up in 32 bits and silently wrap.
            oid_acc = {oid_acc[24:0], b[6:0]};
            if (!b[7]) begin
              res[k] = make_result(K_OID, 8'd0, oid_acc, 4'(oid_emitted), 1'b0);
              k++;
              oid_emitted++;
              oid_acc = 32'd0;
            end
          end
        end
        first_body = 1'b0;
        if (left_bytes > 32'd0) left_bytes--;
        if (left_bytes == 32'd0) done = 1'b1;
      end
    endcase
    if (!bad_count) begin
      // Completion wins over end_of_buffer on the same byte.
      if (done) begin
        res[k] = make_result(K_DONE, 8'd0, 32'd0, 4'd0, 1'b0);
        k++;
        parse_phase = PH_TAG;
      end else if (eob) begin
        res[k] = make_result(K_ERR, 8'd0, 32'd0, 4'd0, CAUSE_EARLY_END);
        k++;
        parse_phase = PH_TAG;
      end
    end
    if (k > 0) res[k-1].last = 1'b1;
    for (int i = 0; i < k; i++) owed_q.push_back(res[i]);
  endtask

  // --------------------------------------------------------------------------
  // Random idling. Most gaps are zero or short and a few are long, so that
  // pauses land on every parse phase and on every slot of a result bundle.
  // --------------------------------------------------------------------------
  function automatic int draw_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Driver. An item is accepted at an edge where in_valid is high and
  // in_stall is low; the predictor takes it at that same edge. A stalled item
  // is held unchanged. After each item a random gap is drawn.
  // --------------------------------------------------------------------------
  int        send_gap = 0;
  tlv_byte_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(data_byte, end_of_buffer);
        bytes_fed++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_item = byte_q.pop_front();
          in_valid      <= 1'b1;
          data_byte     <= next_item.octet;
          end_of_buffer <= next_item.eob;
          send_gap = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. A result is taken at an edge where out_valid is high and
  // out_stall is low, and checked field by field against the oldest result
  // still owed. The stall pattern runs whether or not a result is waiting.
  // --------------------------------------------------------------------------
  int stall_run = 0;

  function automatic void check_field(string name, logic [63:0] want,
                                      logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_result();
    tlv_result_t want;
    if (owed_q.size() == 0) begin
      $error("result with nothing owed: kind %0d, tag 0x%0h", kind, element_tag);
      fail_count++;
      return;
    end
    want = owed_q.pop_front();
    results_checked++;
    kind_seen[want.kind]++;
    check_field("kind",           64'(want.kind),  64'(kind));
    check_field("element_tag",    64'(want.tag),   64'(element_tag));
    check_field("payload_byte",   64'(want.pbyte), 64'(payload_byte));
    check_field("oid_part",       64'(want.part),  64'(oid_part));
    check_field("oid_part_index", 64'(want.idx),   64'(oid_part_index));
    check_field("content_length", 64'(want.clen),  64'(content_length));
    check_field("int_value",      want.ival,       int_value);
    check_field("error_cause",    64'(want.cause), 64'(error_cause));
    check_field("last_of_run",    64'(want.last),  64'(last_of_run));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_run = draw_gap();
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no item moved for %0d cycles, %0d results still owed",
               QUIET_LIMIT, owed_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  logic [7:0] elem_bytes[$];

  function automatic void push_byte(logic [7:0] b, logic e);
    tlv_byte_t t;
    t.octet = b;
    t.eob   = e;
    byte_q.push_back(t);
    items_queued++;
  endfunction

  // Content bytes lean toward the sign and magnitude extremes.
  function automatic logic [7:0] rand_octet();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_tag();
    if ($urandom_range(0, 4) < 2) return OID_TAG;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly short elements; the longest ones give OIDs enough room to run
  // past the component limit.
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 2);
    if (r < 60) return $urandom_range(3, 10);
    if (r < 90) return $urandom_range(11, 24);
    return $urandom_range(25, 40);
  endfunction

  // Short form about half the time, else a long form of one to four bytes,
  // which for these small lengths means leading zero bytes.
  function automatic int pick_form();
    if ($urandom_range(0, 99) < 55) return 0;
    return $urandom_range(1, 4);
  endfunction

  // OID content: a first byte, then components of one to six base-128 digits.
  // Six digits overflow 32 bits, which exercises the wrap.
  function automatic void add_oid_body(int n);
    int left;
    int plen;
    left = n;
    if (left == 0) return;
    elem_bytes.push_back(rand_octet());
    left--;
    while (left > 0) begin
      plen = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(2, 6);
      if (plen > left) plen = left;
      for (int j = 0; j < plen - 1; j++)
        elem_bytes.push_back(HIGH_BIT | 8'($urandom_range(0, 127)));
      elem_bytes.push_back(8'($urandom_range(0, 127)));
      left -= plen;
    end
  endfunction

  // Queues one element: tag, length in the chosen form, then content. When
  // cut_short is set the buffer ends somewhere before the element is
  // complete. Content is capped at 64 bytes, so a larger declared length is
  // only used for cut elements.
  task automatic queue_element(input logic [7:0] tag, input logic [31:0] dlen,
                               input int nlen, input bit cut_short);
    int body_len;
    int stop;
    elem_bytes.delete();
    elem_bytes.push_back(tag);
    if (nlen == 0) begin
      elem_bytes.push_back(dlen[7:0]);
    end else begin
      elem_bytes.push_back(HIGH_BIT | 8'(nlen));
      for (int i = nlen - 1; i >= 0; i--) elem_bytes.push_back(dlen[8*i +: 8]);
    end
    body_len = (dlen > 32'd64) ? 64 : int'(dlen);
    if (tag == OID_TAG && $urandom_range(0, 4) != 0) begin
      add_oid_body(body_len);
    end else begin
      for (int i = 0; i < body_len; i++) elem_bytes.push_back(rand_octet());
    end
    stop = cut_short ? $urandom_range(1, elem_bytes.size() - 1) : elem_bytes.size();
    for (int i = 0; i < stop; i++)
      push_byte(elem_bytes[i],
                (i == stop - 1) && (cut_short || $urandom_range(0, 3) == 0));
  endtask

  // Random mix: mostly complete elements with random content, and some
  // elements cut short, bad long-form counts and plain noise. Noise usually
  // ends on end_of_buffer, which brings the parser back to a tag.
  task automatic queue_random(input int upto);
    int r;
    int nlen;
    int n;
    while (items_queued < upto) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        queue_element(pick_tag(), 32'(pick_length()), pick_form(), 1'b0);
      end else if (r < 82) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_element(pick_tag(), 32'(pick_length()), pick_form(), 1'b1);
        end else begin
          // Any 32-bit declared length, so every bit of content_length moves.
          nlen = $urandom_range(1, 4);
          queue_element(pick_tag(), $urandom >> (8 * (4 - nlen)), nlen, 1'b1);
        end
      end else if (r < 91) begin
        push_byte(pick_tag(), 1'b0);
        if ($urandom_range(0, 1) == 0) push_byte(HIGH_BIT, 1'($urandom_range(0, 1)));
        else push_byte(8'($urandom_range(8'h85, 8'hFF)), 1'($urandom_range(0, 1)));
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          push_byte(8'($urandom_range(0, 255)),
                    (i == n - 1) ? ($urandom_range(0, 4) != 0)
                                 : ($urandom_range(0, 6) == 0));
      end
    end
  endtask

  // Holds the test sequence back until every queued byte went in and every owed
  // result came out.
  task automatic drain_all();
    do @(negedge clk);
    while (byte_q.size() != 0 || in_valid || owed_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    // Directed part. Zero-length element in short form.
    push_byte(8'h02, 1'b0);
    push_byte(8'h00, 1'b0);
    // Two content bytes starting with 0x80: the integer goes negative.
    push_byte(8'h02, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    // OID with a one-byte long form: 43 splits into 1 and 3, then one
    // component of two digits.
    push_byte(OID_TAG, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h2B, 1'b0);
    push_byte(8'h86, 1'b0);
    push_byte(8'h48, 1'b0);
    // Long form that announces no length bytes.
    push_byte(8'h30, 1'b0);
    push_byte(HIGH_BIT, 1'b0);
    // Long form with too many length bytes, ending the buffer at the same
    // time: still a single error.
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    // Four-byte long form of zero; the element completes on its last length
    // byte, so the end of the buffer there is no error.
    push_byte(8'hFF, 1'b0);
    push_byte(8'h84, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // Buffer ending on a tag byte.
    push_byte(8'h00, 1'b1);
    // Buffer ending inside content.
    push_byte(8'h04, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h7F, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Let the directed bytes run out completely before going on.
    drain_all();

    // A stretch with no idling on either side.
    calm = 1'b1;
    queue_random(items_queued + 100);
    drain_all();

    // The bulk of the random part with gaps and stalls.
    calm = 1'b0;
    queue_random(items_queued + 320);
    drain_all();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (owed_q.size() != 0) begin
      $error("%0d results never arrived", owed_q.size());
      fail_count++;
    end

    $display("Fed %0d bytes and checked %0d results: %0d content bytes,",
             bytes_fed, results_checked, kind_seen[K_BYTE]);
    $display("%0d OID components, %0d finished elements, %0d errors.",
             kind_seen[K_OID], kind_seen[K_DONE], kind_seen[K_ERR]);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: ber_tlv_element_decoder_top.f
rtl/btlv_pkg.sv
rtl/btlv_step.sv
rtl/ber_tlv_element_decoder_top.sv
sim/ber_tlv_element_decoder_top_test.sv
